>>> hw/rtl/wsrt_pkg.sv
package wsrt_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int SPEED_BITS  = 24;
  localparam int FIELD_BITS  = 24;
  localparam int Q16_BITS    = 17;
  localparam int DIST_BITS   = 32;
  localparam int MODE_BITS   = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Shared multiplier: operand A covers counts, speed sums and targets.
  localparam int MUL_A0_BITS = (COUNT_BITS > SPEED_BITS + 1) ? COUNT_BITS : SPEED_BITS + 1;
  localparam int MUL_A_BITS  = (MUL_A0_BITS > FIELD_BITS + 1) ? MUL_A0_BITS : FIELD_BITS + 1;
  localparam int PROD_BITS   = MUL_A_BITS + Q16_BITS;
  localparam int DSUM_BITS   = ((MUL_A_BITS > DIST_BITS) ? MUL_A_BITS : DIST_BITS) + 1;

  localparam logic [Q16_BITS-1:0] Q16_ONE = Q16_BITS'(65536);

  localparam logic [1:0] REQ_LEFT  = 2'd0;
  localparam logic [1:0] REQ_RIGHT = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [MODE_BITS-1:0] MODE_STEPPED   = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_GRADUAL_A = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_GRADUAL_B = 3'd3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SPEED_SCALE    = 3'd0,
    CFG_FILTER_ALPHA   = 3'd1,
    CFG_PULSE_DEADZONE = 3'd2,
    CFG_ZERO_THRESHOLD = 3'd3,
    CFG_RAMP_UP_STEP   = 3'd4,
    CFG_RAMP_DOWN_STEP = 3'd5,
    CFG_TICK_PERIOD    = 3'd6,
    CFG_MIN_COMMAND    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0]         speed_scale;
    logic [Q16_BITS-1:0] filter_alpha;
    logic [7:0]          pulse_deadzone;
    logic [23:0]         zero_threshold;
    logic [Q16_BITS-1:0] ramp_up_step;
    logic [Q16_BITS-1:0] ramp_down_step;
    logic [15:0]         tick_period;
    logic [23:0]         min_command;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic                  running;
    logic [MODE_BITS-1:0]  task_mode;
    logic                  stop_request;
    logic [FIELD_BITS-1:0] target_left;
    logic [FIELD_BITS-1:0] target_right;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] speed_left;
    logic [FIELD_BITS-1:0] speed_right;
    logic [Q16_BITS-1:0]   ramp_level;
    logic [FIELD_BITS-1:0] command_left;
    logic [FIELD_BITS-1:0] command_right;
    logic [DIST_BITS-1:0]  distance;
    logic                  drive_enable;
  } out_item_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RAW_L,
    MUL_RAW_R,
    MUL_FILT_L,
    MUL_NEW_L,
    MUL_FILT_R,
    MUL_NEW_R,
    MUL_CMD_L,
    MUL_DIST,
    MUL_CMD_R
  } mul_sel_t;

  typedef enum logic [3:0] {
    USE_NONE,
    USE_RAW_L,
    USE_RAW_R,
    USE_ACC,
    USE_FILT_L,
    USE_FILT_R,
    USE_CMD_L,
    USE_DIST,
    USE_CMD_R
  } use_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW_L,
    ST_RAW_R,
    ST_FILT_L0,
    ST_FILT_L1,
    ST_FILT_R0,
    ST_FILT_R1,
    ST_CMD_L,
    ST_DIST,
    ST_CMD_R,
    ST_WRAP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic     count_left;
    logic     count_right;
    logic     start_tick;
    mul_sel_t mul_sel;
    use_sel_t use_sel;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_left;
    logic is_right;
    logic is_active_tick;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/wsrt_cfg_regs.sv
module wsrt_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsrt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [wsrt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output wsrt_pkg::cfg_t                      cfg
);

  // Writes are to arrive only while the block is idle; the block does not enforce it. The port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_scale    <= 16'd0;
      cfg.filter_alpha   <= wsrt_pkg::Q16_BITS'(32768);
      cfg.pulse_deadzone <= 8'd2;
      cfg.zero_threshold <= 24'd256;
      cfg.ramp_up_step   <= wsrt_pkg::Q16_BITS'(6554);
      cfg.ramp_down_step <= wsrt_pkg::Q16_BITS'(7864);
      cfg.tick_period    <= 16'd3277;
      cfg.min_command    <= 24'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (wsrt_pkg::cfg_idx_t'(cfg_index))
        wsrt_pkg::CFG_SPEED_SCALE:    cfg.speed_scale    <= cfg_data[15:0];
        wsrt_pkg::CFG_FILTER_ALPHA:   cfg.filter_alpha   <= cfg_data[16:0];
        wsrt_pkg::CFG_PULSE_DEADZONE: cfg.pulse_deadzone <= cfg_data[7:0];
        wsrt_pkg::CFG_ZERO_THRESHOLD: cfg.zero_threshold <= cfg_data[23:0];
        wsrt_pkg::CFG_RAMP_UP_STEP:   cfg.ramp_up_step   <= cfg_data[16:0];
        wsrt_pkg::CFG_RAMP_DOWN_STEP: cfg.ramp_down_step <= cfg_data[16:0];
        wsrt_pkg::CFG_TICK_PERIOD:    cfg.tick_period    <= cfg_data[15:0];
        wsrt_pkg::CFG_MIN_COMMAND:    cfg.min_command    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/wsrt_ctrl.sv
module wsrt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  wsrt_pkg::dp_status_t status,
  output wsrt_pkg::dp_cmd_t    cmd
);

  wsrt_pkg::state_t state, state_next;
  logic             accept;

  assign item_stall = (state != wsrt_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // States RAW_L..CMD_R start a multiply; RAW_R..WRAP use the last product.
  always_comb begin
    state_next       = state;
    cmd.count_left   = 1'b0;
    cmd.count_right  = 1'b0;
    cmd.start_tick   = 1'b0;
    cmd.mul_sel      = wsrt_pkg::MUL_NONE;
    cmd.use_sel      = wsrt_pkg::USE_NONE;
    cmd.load_out     = 1'b0;
    case (state)
      wsrt_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.count_left  = status.is_left;
          cmd.count_right = status.is_right;
          if (status.is_active_tick) begin
            cmd.start_tick = 1'b1;
            state_next     = wsrt_pkg::ST_RAW_L;
          end
        end
      end
      wsrt_pkg::ST_RAW_L: begin
        cmd.mul_sel = wsrt_pkg::MUL_RAW_L;
        state_next  = wsrt_pkg::ST_RAW_R;
      end
      wsrt_pkg::ST_RAW_R: begin
        cmd.mul_sel = wsrt_pkg::MUL_RAW_R;
        cmd.use_sel = wsrt_pkg::USE_RAW_L;
        state_next  = wsrt_pkg::ST_FILT_L0;
      end
      wsrt_pkg::ST_FILT_L0: begin
        cmd.mul_sel = wsrt_pkg::MUL_FILT_L;
        cmd.use_sel = wsrt_pkg::USE_RAW_R;
        state_next  = wsrt_pkg::ST_FILT_L1;
      end
      wsrt_pkg::ST_FILT_L1: begin
        cmd.mul_sel = wsrt_pkg::MUL_NEW_L;
        cmd.use_sel = wsrt_pkg::USE_ACC;
        state_next  = wsrt_pkg::ST_FILT_R0;
      end
      wsrt_pkg::ST_FILT_R0: begin
        cmd.mul_sel = wsrt_pkg::MUL_FILT_R;
        cmd.use_sel = wsrt_pkg::USE_FILT_L;
        state_next  = wsrt_pkg::ST_FILT_R1;
      end
      wsrt_pkg::ST_FILT_R1: begin
        cmd.mul_sel = wsrt_pkg::MUL_NEW_R;
        cmd.use_sel = wsrt_pkg::USE_ACC;
        state_next  = wsrt_pkg::ST_CMD_L;
      end
      wsrt_pkg::ST_CMD_L: begin
        cmd.mul_sel = wsrt_pkg::MUL_CMD_L;
        cmd.use_sel = wsrt_pkg::USE_FILT_R;
        state_next  = wsrt_pkg::ST_DIST;
      end
      wsrt_pkg::ST_DIST: begin
        cmd.mul_sel = wsrt_pkg::MUL_DIST;
        cmd.use_sel = wsrt_pkg::USE_CMD_L;
        state_next  = wsrt_pkg::ST_CMD_R;
      end
      wsrt_pkg::ST_CMD_R: begin
        cmd.mul_sel = wsrt_pkg::MUL_CMD_R;
        cmd.use_sel = wsrt_pkg::USE_DIST;
        state_next  = wsrt_pkg::ST_WRAP;
      end
      wsrt_pkg::ST_WRAP: begin
        cmd.use_sel = wsrt_pkg::USE_CMD_R;
        state_next  = wsrt_pkg::ST_FINISH;
      end
      wsrt_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = wsrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wsrt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/wsrt_datapath.sv
module wsrt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  wsrt_pkg::in_item_t   item,
  input  wsrt_pkg::cfg_t       cfg,
  input  wsrt_pkg::dp_cmd_t    cmd,
  output wsrt_pkg::dp_status_t status,
  output logic                 result_valid,
  input  logic                 result_stall,
  output wsrt_pkg::out_item_t  result
);

  localparam int SB = wsrt_pkg::SPEED_BITS;
  localparam int CB = wsrt_pkg::COUNT_BITS;
  localparam int QB = wsrt_pkg::Q16_BITS;
  localparam int FB = wsrt_pkg::FIELD_BITS;
  localparam int AB = wsrt_pkg::MUL_A_BITS;
  localparam int PB = wsrt_pkg::PROD_BITS;
  localparam int DB = wsrt_pkg::DIST_BITS;
  localparam int XB = wsrt_pkg::DSUM_BITS;
  localparam int TB = (SB > 24) ? SB : 24;

  localparam logic [SB-1:0] SPEED_MAX = {SB{1'b1}};
  localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};
  localparam logic [DB-1:0] DIST_MAX  = {DB{1'b1}};

  logic [CB-1:0] pulses_left, pulses_right;
  logic [SB-1:0] filt_left, filt_right;
  logic [SB-1:0] raw_left, raw_right;
  logic [QB-1:0] ramp;
  logic [DB-1:0] distance_total;
  logic [PB-1:0] acc, prod;
  logic [FB-1:0] target_left, target_right;
  logic          stop;
  logic [FB-1:0] cmd_left, cmd_right;

  logic [QB-1:0] alpha, alpha_inv;
  logic [QB-1:0] ramp_next;
  logic [QB:0]   ramp_up_sum;
  logic [AB-1:0] mul_a;
  logic [QB-1:0] mul_b;
  logic [AB-1:0] dist_step;
  logic [XB-1:0] dist_sum;
  logic          mode_ok;

  function automatic logic [SB-1:0] saturate_raw(input logic [PB-1:0] p);
    if (p > PB'(SPEED_MAX)) begin
      return SPEED_MAX;
    end
    return p[SB-1:0];
  endfunction

  // Without a fresh sample the speed halves and snaps to zero below threshold.
  function automatic logic [SB-1:0] filter_update(input logic [SB-1:0] raw,
                                                  input logic [SB-1:0] filt,
                                                  input logic [PB-1:0] old_part,
                                                  input logic [PB-1:0] new_part,
                                                  input logic [23:0]   zero_thr);
    logic [SB-1:0] half;
    logic [PB:0]   blend;
    logic [PB:0]   shifted;
    half    = filt >> 1;
    blend   = (PB + 1)'(old_part) + (PB + 1)'(new_part) + (PB + 1)'(32768);
    shifted = blend >> 16;
    if (raw == '0) begin
      if (TB'(half) < TB'(zero_thr)) begin
        return '0;
      end
      return half;
    end
    if (shifted > (PB + 1)'(SPEED_MAX)) begin
      return SPEED_MAX;
    end
    return shifted[SB-1:0];
  endfunction

  function automatic logic [FB-1:0] speed_field(input logic [SB-1:0] s);
    logic [SB+FB-1:0] t;
    t = (SB + FB)'(s);
    return t[FB-1:0];
  endfunction

  assign mode_ok = (item.task_mode == wsrt_pkg::MODE_STEPPED) ||
                   (item.task_mode == wsrt_pkg::MODE_GRADUAL_A) ||
                   (item.task_mode == wsrt_pkg::MODE_GRADUAL_B);

  assign status.is_left        = (item.req_type == wsrt_pkg::REQ_LEFT);
  assign status.is_right       = (item.req_type == wsrt_pkg::REQ_RIGHT);
  assign status.is_active_tick = (item.req_type == wsrt_pkg::REQ_TICK) && item.running && mode_ok;
  assign status.out_free       = !result_valid || !result_stall;

  assign alpha     = (cfg.filter_alpha > wsrt_pkg::Q16_ONE) ? wsrt_pkg::Q16_ONE : cfg.filter_alpha;
  assign alpha_inv = wsrt_pkg::Q16_ONE - alpha;

  assign ramp_up_sum = (QB + 1)'(ramp) + (QB + 1)'(cfg.ramp_up_step);

  always_comb begin
    ramp_next = ramp;
    if (item.task_mode == wsrt_pkg::MODE_STEPPED) begin
      ramp_next = item.stop_request ? '0 : wsrt_pkg::Q16_ONE;
    end else if (!item.stop_request) begin
      if (ramp < wsrt_pkg::Q16_ONE) begin
        ramp_next = (ramp_up_sum > (QB + 1)'(wsrt_pkg::Q16_ONE)) ? wsrt_pkg::Q16_ONE
                                                                 : ramp_up_sum[QB-1:0];
      end
    end else begin
      ramp_next = (ramp > cfg.ramp_down_step) ? ramp - cfg.ramp_down_step : '0;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      wsrt_pkg::MUL_RAW_L: begin
        mul_a = AB'(pulses_left);
        mul_b = QB'(cfg.speed_scale);
      end
      wsrt_pkg::MUL_RAW_R: begin
        mul_a = AB'(pulses_right);
        mul_b = QB'(cfg.speed_scale);
      end
      wsrt_pkg::MUL_FILT_L: begin
        mul_a = AB'(filt_left);
        mul_b = alpha_inv;
      end
      wsrt_pkg::MUL_NEW_L: begin
        mul_a = AB'(raw_left);
        mul_b = alpha;
      end
      wsrt_pkg::MUL_FILT_R: begin
        mul_a = AB'(filt_right);
        mul_b = alpha_inv;
      end
      wsrt_pkg::MUL_NEW_R: begin
        mul_a = AB'(raw_right);
        mul_b = alpha;
      end
      wsrt_pkg::MUL_CMD_L: begin
        mul_a = AB'(target_left);
        mul_b = ramp;
      end
      wsrt_pkg::MUL_DIST: begin
        mul_a = AB'(filt_left) + AB'(filt_right);
        mul_b = QB'(cfg.tick_period);
      end
      wsrt_pkg::MUL_CMD_R: begin
        mul_a = AB'(target_right);
        mul_b = ramp;
      end
      default: ;
    endcase
  end

  assign dist_step = prod[PB-1:17];
  assign dist_sum  = XB'(dist_step) + XB'(distance_total);

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != wsrt_pkg::MUL_NONE) begin
      prod <= PB'(mul_a) * PB'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_left    <= '0;
      pulses_right   <= '0;
      filt_left      <= '0;
      filt_right     <= '0;
      ramp           <= '0;
      distance_total <= '0;
    end else begin
      if (cmd.count_left && pulses_left != COUNT_MAX) begin
        pulses_left <= pulses_left + CB'(1);
      end
      if (cmd.count_right && pulses_right != COUNT_MAX) begin
        pulses_right <= pulses_right + CB'(1);
      end
      if (cmd.start_tick) begin
        ramp <= ramp_next;
      end
      case (cmd.use_sel)
        wsrt_pkg::USE_RAW_R: begin
          // Both counts have been read by now, so the window restarts.
          pulses_left  <= '0;
          pulses_right <= '0;
        end
        wsrt_pkg::USE_FILT_L: begin
          filt_left <= filter_update(raw_left, filt_left, acc, prod, cfg.zero_threshold);
        end
        wsrt_pkg::USE_FILT_R: begin
          filt_right <= filter_update(raw_right, filt_right, acc, prod, cfg.zero_threshold);
        end
        wsrt_pkg::USE_DIST: begin
          if (!stop) begin
            distance_total <= (dist_sum > XB'(DIST_MAX)) ? DIST_MAX : dist_sum[DB-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_tick) begin
      target_left  <= item.target_left;
      target_right <= item.target_right;
      stop         <= item.stop_request;
    end
    case (cmd.use_sel)
      wsrt_pkg::USE_RAW_L: begin
        raw_left <= (pulses_left >= CB'(cfg.pulse_deadzone)) ? saturate_raw(prod) : '0;
      end
      wsrt_pkg::USE_RAW_R: begin
        raw_right <= (pulses_right >= CB'(cfg.pulse_deadzone)) ? saturate_raw(prod) : '0;
      end
      wsrt_pkg::USE_ACC: begin
        acc <= prod;
      end
      wsrt_pkg::USE_CMD_L: begin
        cmd_left <= prod[16+FB-1:16];
      end
      wsrt_pkg::USE_CMD_R: begin
        cmd_right <= prod[16+FB-1:16];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.speed_left    <= speed_field(filt_left);
      result.speed_right   <= speed_field(filt_right);
      result.ramp_level    <= ramp;
      result.command_left  <= cmd_left;
      result.command_right <= cmd_right;
      result.distance      <= distance_total;
      result.drive_enable  <= !((cmd_left < cfg.min_command) && (cmd_right < cfg.min_command));
    end
  end

endmodule

>>> hw/rtl/wheel_speed_ramp_tick_unit.sv
// Channel   Handshake                 Payload
// item      item_valid / item_stall   item   (wsrt_pkg::in_item_t)
// result    result_valid / result_stall  result (wsrt_pkg::out_item_t)
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A pulse transaction or an inactive tick is taken in the idle state. An active tick
// is accepted, then runs nine steps through the single shared 25x17 multiplier,
// one step to close the last product, and one to load the result register.
// Reset is synchronous; it restores register defaults and clears counts, speeds,
// ramp and distance. A stalled result holds in its register while pulses keep
// being counted; the next active tick waits at its last step until it drains.
module wheel_speed_ramp_tick_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  wsrt_pkg::in_item_t                  item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output wsrt_pkg::out_item_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsrt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [wsrt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  wsrt_pkg::cfg_t       cfg;
  wsrt_pkg::dp_cmd_t    cmd;
  wsrt_pkg::dp_status_t status;

  wsrt_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wsrt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  wsrt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> sim/tb_wheel_speed_ramp_tick_unit.sv
module tb_wheel_speed_ramp_tick_unit;
  import wsrt_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_SHOWN     = 10;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 52;
  localparam int SAT_PULSES    = 24;
  localparam int DIST_TICKS    = 24;

  localparam logic [1:0]           REQ_UNDEF  = 2'd3;
  localparam logic [MODE_BITS-1:0] MODE_OFF   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_TOP   = 3'd7;
  localparam logic [23:0]          FULL24     = 24'hFFFFFF;
  localparam logic [63:0]          SPEED_MAX  = 64'((64'd1 << SPEED_BITS) - 1);
  localparam logic [63:0]          DIST_MAX   = 64'((64'd1 << DIST_BITS) - 1);

  typedef enum {SET_ONES, SET_ZERO, SET_TYPICAL, SET_RANDOM, SET_HOLD} setting_t;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                     clk;
  logic                     rst;
  logic                     item_valid;
  logic                     item_stall;
  in_item_t                 item;
  logic                     result_valid;
  logic                     result_stall;
  out_item_t                result;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  wheel_speed_ramp_tick_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow copy of the block's registers and wheel state.
  cfg_t                  shadow_regs;
  logic [COUNT_BITS-1:0] cnt_left;
  logic [COUNT_BITS-1:0] cnt_right;
  logic [SPEED_BITS-1:0] filt_left;
  logic [SPEED_BITS-1:0] filt_right;
  logic [Q16_BITS-1:0]   ramp_q16;
  logic [DIST_BITS-1:0]  dist_acc;

  out_item_t   pending_reports[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  dir_row_t    dir_rows[19];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_wheel_speed_ramp_tick_unit: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= (rcv_stall_pct != 0) && ($urandom_range(99) < rcv_stall_pct);
  end

  task automatic show_report(input string tag, input out_item_t r);
    $display("  %s: speed %h/%h ramp %h cmd %h/%h dist %h en %b", tag, r.speed_left,
             r.speed_right, r.ramp_level, r.command_left, r.command_right, r.distance,
             r.drive_enable);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_reports.size() == 0) begin
        if (mismatches < MAX_SHOWN) begin
          $display("unexpected result transaction at cycle %0d", cycles);
          show_report("actual", result);
        end
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (result.speed_left !== want.speed_left || result.speed_right !== want.speed_right ||
            result.ramp_level !== want.ramp_level ||
            result.command_left !== want.command_left ||
            result.command_right !== want.command_right ||
            result.distance !== want.distance || result.drive_enable !== want.drive_enable) begin
          if (mismatches < MAX_SHOWN) begin
            $display("result mismatch at cycle %0d", cycles);
            show_report("expected", want);
            show_report("actual", result);
          end
          mismatches++;
        end
      end
    end
  end

  function automatic logic [SPEED_BITS-1:0] next_speed(input logic [COUNT_BITS-1:0] count,
                                                       input logic [SPEED_BITS-1:0] filt);
    logic [63:0] raw;
    logic [63:0] alpha;
    logic [63:0] acc;
    raw = '0;
    if (count >= shadow_regs.pulse_deadzone) begin
      raw = 64'(count) * 64'(shadow_regs.speed_scale);
      if (raw > SPEED_MAX) raw = SPEED_MAX;
    end
    // No usable pulses: the estimate decays and snaps to zero when small.
    if (raw == 0) begin
      acc = 64'(filt) >> 1;
      if (acc < 64'(shadow_regs.zero_threshold)) acc = '0;
      return acc[SPEED_BITS-1:0];
    end
    alpha = 64'(shadow_regs.filter_alpha);
    if (alpha > 64'(Q16_ONE)) alpha = 64'(Q16_ONE);
    acc = (64'(filt) * (64'(Q16_ONE) - alpha) + raw * alpha + 64'd32768) >> 16;
    if (acc > SPEED_MAX) acc = SPEED_MAX;
    return acc[SPEED_BITS-1:0];
  endfunction

  // Advances the shadow state by one input transaction; returns 1 when a result is due.
  function automatic bit apply_item(input in_item_t it, output out_item_t rep);
    logic [63:0] ramp;
    logic [63:0] step;
    logic [63:0] cl;
    logic [63:0] cr;
    rep = '0;
    if (it.req_type == REQ_LEFT) begin
      if (cnt_left != '1) cnt_left = cnt_left + 1'b1;
      return 1'b0;
    end
    if (it.req_type == REQ_RIGHT) begin
      if (cnt_right != '1) cnt_right = cnt_right + 1'b1;
      return 1'b0;
    end
    if (it.req_type != REQ_TICK || !it.running || it.task_mode < MODE_STEPPED ||
        it.task_mode > MODE_GRADUAL_B) begin
      return 1'b0;
    end

    ramp = 64'(ramp_q16);
    if (it.task_mode == MODE_STEPPED) begin
      ramp = it.stop_request ? 64'd0 : 64'(Q16_ONE);
    end else if (!it.stop_request) begin
      if (ramp < 64'(Q16_ONE)) begin
        ramp = ramp + 64'(shadow_regs.ramp_up_step);
        if (ramp > 64'(Q16_ONE)) ramp = 64'(Q16_ONE);
      end
    end else begin
      ramp = (ramp > 64'(shadow_regs.ramp_down_step)) ?
             ramp - 64'(shadow_regs.ramp_down_step) : 64'd0;
    end
    ramp_q16 = ramp[Q16_BITS-1:0];

    filt_left  = next_speed(cnt_left, filt_left);
    filt_right = next_speed(cnt_right, filt_right);
    cnt_left   = '0;
    cnt_right  = '0;

    if (!it.stop_request) begin
      step = ((64'(filt_left) + 64'(filt_right)) * 64'(shadow_regs.tick_period)) >> 17;
      step = step + 64'(dist_acc);
      dist_acc = (step > DIST_MAX) ? '1 : step[DIST_BITS-1:0];
    end

    cl = (64'(it.target_left) * ramp) >> 16;
    cr = (64'(it.target_right) * ramp) >> 16;

    rep.speed_left    = filt_left;
    rep.speed_right   = filt_right;
    rep.ramp_level    = ramp_q16;
    rep.command_left  = cl[FIELD_BITS-1:0];
    rep.command_right = cr[FIELD_BITS-1:0];
    rep.distance      = dist_acc;
    rep.drive_enable  = !(cl < 64'(shadow_regs.min_command) &&
                          cr < 64'(shadow_regs.min_command));
    return 1'b1;
  endfunction

  task automatic send_item(input in_item_t stim, input bit typed, input out_item_t want);
    out_item_t calc;
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= stim;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (apply_item(stim, calc)) pending_reports.push_back(typed ? want : calc);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SPEED_SCALE:    shadow_regs.speed_scale    = data[15:0];
      CFG_FILTER_ALPHA:   shadow_regs.filter_alpha   = data[Q16_BITS-1:0];
      CFG_PULSE_DEADZONE: shadow_regs.pulse_deadzone = data[7:0];
      CFG_ZERO_THRESHOLD: shadow_regs.zero_threshold = data[23:0];
      CFG_RAMP_UP_STEP:   shadow_regs.ramp_up_step   = data[Q16_BITS-1:0];
      CFG_RAMP_DOWN_STEP: shadow_regs.ramp_down_step = data[Q16_BITS-1:0];
      CFG_TICK_PERIOD:    shadow_regs.tick_period    = data[15:0];
      CFG_MIN_COMMAND:    shadow_regs.min_command    = data[23:0];
      default: ;
    endcase
  endtask

  function automatic logic [23:0] cfg_pick(input setting_t s, input cfg_idx_t idx);
    case (s)
      SET_ONES: return FULL24;
      SET_ZERO: return '0;
      SET_TYPICAL, SET_HOLD: begin
        case (idx)
          CFG_SPEED_SCALE:    return (s == SET_HOLD) ? 24'd65535 : 24'd300;
          CFG_FILTER_ALPHA:   return (s == SET_HOLD) ? 24'd65536 : 24'd20000;
          CFG_PULSE_DEADZONE: return (s == SET_HOLD) ? 24'd0 : 24'd3;
          CFG_ZERO_THRESHOLD: return (s == SET_HOLD) ? 24'd0 : 24'd256;
          CFG_RAMP_UP_STEP:   return 24'd6554;
          CFG_RAMP_DOWN_STEP: return 24'd7864;
          CFG_TICK_PERIOD:    return (s == SET_HOLD) ? 24'd65535 : 24'd3277;
          default:            return 24'd512;
        endcase
      end
      default: begin
        case ($urandom_range(3))
          0: return 24'($urandom);
          1: return '0;
          2: return FULL24;
          default: begin
            case (idx)
              CFG_SPEED_SCALE:    return 24'($urandom_range(1, 2000));
              CFG_FILTER_ALPHA:   return 24'($urandom_range(0, 65536));
              CFG_PULSE_DEADZONE: return 24'($urandom_range(0, 8));
              CFG_ZERO_THRESHOLD: return 24'($urandom_range(0, 2000));
              CFG_RAMP_UP_STEP,
              CFG_RAMP_DOWN_STEP: return 24'($urandom_range(1, 70000));
              CFG_TICK_PERIOD:    return 24'($urandom);
              default:            return 24'($urandom_range(0, 1 << 20));
            endcase
          end
        endcase
      end
    endcase
  endfunction

  // Registers change only with no tick in flight and no result outstanding.
  task automatic configure(input setting_t s);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 8; i++) write_cfg(cfg_idx_t'(i), cfg_pick(s, cfg_idx_t'(i)));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [FIELD_BITS-1:0] random_target();
    case ($urandom_range(5))
      0: return '0;
      1: return FULL24;
      default: return FIELD_BITS'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.req_type     = 2'($urandom);
    it.running      = 1'($urandom);
    it.task_mode    = MODE_BITS'($urandom);
    it.stop_request = 1'($urandom);
    it.target_left  = random_target();
    it.target_right = random_target();
    return it;
  endfunction

  // Bursts of pulses closed by a tick; one closer in seven is left as random noise.
  task automatic run_random(input int n);
    int         sent;
    int         burst;
    bit         one_side;
    logic [1:0] side;
    in_item_t   it;
    sent = 0;
    while (sent < n) begin
      burst    = ($urandom_range(24) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      one_side = ($urandom_range(3) == 0);
      side     = $urandom_range(1) ? REQ_LEFT : REQ_RIGHT;
      for (int k = 0; k < burst; k++) begin
        it = random_item();
        it.req_type = one_side ? side : ($urandom_range(1) ? REQ_LEFT : REQ_RIGHT);
        send_item(it, 1'b0, '0);
      end
      it = random_item();
      if ($urandom_range(6) != 0) begin
        it.req_type = REQ_TICK;
        it.running  = 1'b1;
        case ($urandom_range(4))
          0:       it.task_mode = MODE_STEPPED;
          1, 2:    it.task_mode = MODE_GRADUAL_A;
          default: it.task_mode = MODE_GRADUAL_B;
        endcase
        it.stop_request = ($urandom_range(2) == 0);
      end
      send_item(it, 1'b0, '0);
      sent += burst + 1;
    end
  endtask

  initial begin
    setting_t s;
    in_item_t it;

    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item         <= '0;
    result_stall <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;

    shadow_regs.speed_scale    = 16'd0;
    shadow_regs.filter_alpha   = 17'd32768;
    shadow_regs.pulse_deadzone = 8'd2;
    shadow_regs.zero_threshold = 24'd256;
    shadow_regs.ramp_up_step   = 17'd6554;
    shadow_regs.ramp_down_step = 17'd7864;
    shadow_regs.tick_period    = 16'd3277;
    shadow_regs.min_command    = 24'd512;
    cnt_left   = '0;
    cnt_right  = '0;
    filt_left  = '0;
    filt_right = '0;
    ramp_q16   = '0;
    dist_acc   = '0;

    // Rows with a typed result are fixed by reset state: no speed yet, so
    // distance stays zero and commands are the targets at full or zero ramp.
    dir_rows = '{
      '{'{REQ_TICK, 1'b0, MODE_GRADUAL_A, 1'b0, 24'h000123, 24'h000456}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_OFF, 1'b0, FULL24, FULL24}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_SPARE, 1'b0, FULL24, 24'd0}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_TOP, 1'b1, FULL24, FULL24}, 1'b0, '0},
      '{'{REQ_UNDEF, 1'b1, MODE_GRADUAL_A, 1'b0, FULL24, FULL24}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_STEPPED, 1'b0, 24'd0, 24'd0}, 1'b1,
        '{24'd0, 24'd0, Q16_ONE, 24'd0, 24'd0, 32'd0, 1'b0}},
      '{'{REQ_TICK, 1'b1, MODE_STEPPED, 1'b0, FULL24, FULL24}, 1'b1,
        '{24'd0, 24'd0, Q16_ONE, FULL24, FULL24, 32'd0, 1'b1}},
      '{'{REQ_TICK, 1'b1, MODE_STEPPED, 1'b1, FULL24, FULL24}, 1'b1,
        '{24'd0, 24'd0, 17'd0, 24'd0, 24'd0, 32'd0, 1'b0}},
      '{'{REQ_LEFT, 1'b1, MODE_TOP, 1'b1, FULL24, FULL24}, 1'b0, '0},
      '{'{REQ_LEFT, 1'b0, MODE_OFF, 1'b0, 24'd0, 24'd0}, 1'b0, '0},
      '{'{REQ_RIGHT, 1'b1, MODE_GRADUAL_B, 1'b1, FULL24, 24'd0}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_GRADUAL_A, 1'b0, FULL24, 24'd0}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_GRADUAL_B, 1'b0, 24'd0, FULL24}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_GRADUAL_B, 1'b1, FULL24, FULL24}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_GRADUAL_A, 1'b1, FULL24, FULL24}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_GRADUAL_A, 1'b1, FULL24, FULL24}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_STEPPED, 1'b0, 24'h000200, 24'h0001FF}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_GRADUAL_B, 1'b0, 24'h800000, 24'h000001}, 1'b0, '0},
      '{'{REQ_TICK, 1'b1, MODE_GRADUAL_A, 1'b1, 24'h000200, 24'h000200}, 1'b0, '0}
    };

    snd_idle_pct  = 36;
    rcv_stall_pct = 62;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    item_valid <= 1'b0;

    for (int p = 1; p <= PHASES; p++) begin
      if (p <= 3) begin
        snd_idle_pct  = 36;
        rcv_stall_pct = 62;
      end else if (p <= 6) begin
        snd_idle_pct  = 62;
        rcv_stall_pct = 36;
      end else begin
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
      end
      case (p)
        1, 9:    s = SET_ONES;
        2:       s = SET_ZERO;
        3:       s = SET_TYPICAL;
        PHASES:  s = SET_HOLD;
        default: s = SET_RANDOM;
      endcase
      configure(s);

      if (p < PHASES) run_random(PHASE_ITEMS);

      // A longer run of pulses on both wheels closed by one tick, with every
      // register at its largest value.
      if (p == 9) begin
        for (int k = 0; k < SAT_PULSES; k++) begin
          it = random_item();
          it.req_type = REQ_LEFT;
          send_item(it, 1'b0, '0);
          it.req_type = REQ_RIGHT;
          send_item(it, 1'b0, '0);
        end
        it = random_item();
        it.req_type     = REQ_TICK;
        it.running      = 1'b1;
        it.task_mode    = MODE_GRADUAL_B;
        it.stop_request = 1'b0;
        send_item(it, 1'b0, '0);
      end

      // With full filter weight one pulse per wheel sets a fixed speed, so distance
      // climbs by the same step on every tick but the last, which follows no pulses.
      if (p == PHASES) begin
        for (int k = 0; k <= DIST_TICKS; k++) begin
          if (k < DIST_TICKS) begin
            it = random_item();
            it.req_type = REQ_LEFT;
            send_item(it, 1'b0, '0);
            it.req_type = REQ_RIGHT;
            send_item(it, 1'b0, '0);
          end
          it = random_item();
          it.req_type     = REQ_TICK;
          it.running      = 1'b1;
          it.task_mode    = MODE_GRADUAL_A;
          it.stop_request = 1'b0;
          send_item(it, 1'b0, '0);
        end
      end
      item_valid <= 1'b0;
    end

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_wheel_speed_ramp_tick_unit: PASS");
    end else begin
      $display("tb_wheel_speed_ramp_tick_unit: FAIL");
    end
    $finish;
  end

endmodule
